// ===== hw/rtl/shep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package shep_pkg;

  localparam int MAX_SIGNALS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ADDR_W = $clog2(MAX_SIGNALS);
  localparam int CNT_W = $clog2(MAX_SIGNALS + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CFG_DET_SEL = 8'd0;
  localparam logic [7:0] CFG_TOL = 8'd1;
  localparam logic [7:0] CFG_DEPTH_POS = 8'd2;
  localparam logic [7:0] CFG_DEPTH_W = 8'd3;

  localparam logic [1:0] K_MEAN = 2'd0;
  localparam logic [1:0] K_SPLIT_X = 2'd1;
  localparam logic [1:0] K_SPLIT_Y = 2'd2;
  localparam logic [1:0] K_DIRECT = 2'd3;

  typedef struct packed {
    logic [15:0]        energy;
    logic signed [15:0] position;
    logic [15:0]        strip_width;
    logic [7:0]         signal_index;
  } sig_t;

  localparam int SIG_W = $bits(sig_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    sig_t              data;
  } ram_wr_t;

  typedef struct packed {
    logic        xs;
    logic        ys;
    logic [1:0]  kind;
  } hit_sel_t;

  typedef struct packed {
    logic [1:0] n;
    hit_sel_t   h0;
    hit_sel_t   h1;
  } plan_t;

  typedef struct packed {
    logic [15:0]        energy;
    logic [15:0]        energy_x;
    logic [15:0]        energy_y;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        width_x;
    logic [15:0]        width_y;
    logic [7:0]         index_x;
    logic [7:0]         index_y;
  } hit_t;

endpackage
`default_nettype wire

// ===== hw/rtl/strip_hit_energy_pairing_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake              words
// in_      in   in_valid/in_ready      one strip signal
// out_     out  out_valid/out_ready    one hit
// cfg_     in   cfg_valid/cfg_ready    register index and data
//
// Signals load at one per cycle; in_ready drops from the last word of an
// event until its hits reach the output stage. Event end fetches the first
// two words of each store; a split hit takes a multiply and a 16-step divide,
// and otherwise a rank sort runs on the stores' single read ports and each
// rank is then read back and paired when within tolerance. Reset clears counts;
// stores are never cleared.
module strip_hit_energy_pairing_unit
  import shep_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_strip_side,
  input  wire logic [7:0]         in_detector_id,
  input  wire logic [15:0]        in_energy,
  input  wire logic signed [15:0] in_position,
  input  wire logic [15:0]        in_strip_width,
  input  wire logic [7:0]         in_signal_index,
  input  wire logic               in_last_of_event,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_hit_energy,
  output logic [15:0]             out_hit_energy_x,
  output logic [15:0]             out_hit_energy_y,
  output logic signed [15:0]      out_hit_pos_x,
  output logic signed [15:0]      out_hit_pos_y,
  output logic signed [15:0]      out_hit_pos_z,
  output logic [15:0]             out_hit_width_x,
  output logic [15:0]             out_hit_width_y,
  output logic [15:0]             out_hit_width_z,
  output logic [7:0]              out_hit_index_x,
  output logic [7:0]              out_hit_index_y,
  output logic                    out_last_hit,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic [7:0]        det_sel_r;
  logic [15:0]       tol_r;
  logic [15:0]       depth_pos_r;
  logic [15:0]       depth_w_r;
  logic              idle;
  logic              in_acc;
  sig_t              in_sig;
  ram_wr_t           x_wr, y_wr;
  logic [ADDR_W-1:0] x_raddr, y_raddr;
  sig_t              x_rdata, y_rdata;
  logic              div_start, div_done;
  logic [31:0]       div_dividend;
  logic [16:0]       div_divisor;
  logic [15:0]       div_q;
  logic              push, push_ok, flush, flush_ok;
  hit_t              hit, out_hit;

  assign in_ready = idle;
  assign in_acc = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign in_sig = '{energy: in_energy, position: in_position,
                    strip_width: in_strip_width, signal_index: in_signal_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_sel_r   <= 8'd0;
      tol_r       <= 16'd80;
      depth_pos_r <= 16'd0;
      depth_w_r   <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DET_SEL:   det_sel_r   <= cfg_data[7:0];
        CFG_TOL:       tol_r       <= cfg_data;
        CFG_DEPTH_POS: depth_pos_r <= cfg_data;
        CFG_DEPTH_W:   depth_w_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  shep_ram #(.WIDTH(SIG_W), .DEPTH(MAX_SIGNALS)) u_xram (
    .clk(clk), .we(x_wr.we), .waddr(x_wr.addr), .wdata(x_wr.data),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  shep_ram #(.WIDTH(SIG_W), .DEPTH(MAX_SIGNALS)) u_yram (
    .clk(clk), .we(y_wr.we), .waddr(y_wr.addr), .wdata(y_wr.data),
    .raddr(y_raddr), .rdata(y_rdata)
  );

  shep_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  shep_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_acc(in_acc), .in_side(in_strip_side),
    .in_det(in_detector_id), .in_last(in_last_of_event), .in_sig(in_sig),
    .det_sel(det_sel_r), .tol(tol_r), .idle(idle),
    .x_wr(x_wr), .x_raddr(x_raddr), .x_rdata(x_rdata),
    .y_wr(y_wr), .y_raddr(y_raddr), .y_rdata(y_rdata),
    .div_start(div_start), .div_dividend(div_dividend), .div_divisor(div_divisor),
    .div_done(div_done), .div_q(div_q),
    .push(push), .hit(hit), .push_ok(push_ok), .flush(flush), .flush_ok(flush_ok)
  );

  shep_obuf u_obuf (
    .clk(clk), .rst_n(rst_n), .push(push), .hit(hit), .push_ok(push_ok),
    .flush(flush), .flush_ok(flush_ok), .out_valid(out_valid),
    .out_ready(out_ready), .out_hit(out_hit), .out_last(out_last_hit)
  );

  assign out_hit_energy   = out_hit.energy;
  assign out_hit_energy_x = out_hit.energy_x;
  assign out_hit_energy_y = out_hit.energy_y;
  assign out_hit_pos_x    = out_hit.pos_x;
  assign out_hit_pos_y    = out_hit.pos_y;
  assign out_hit_pos_z    = depth_pos_r;
  assign out_hit_width_x  = out_hit.width_x;
  assign out_hit_width_y  = out_hit.width_y;
  assign out_hit_width_z  = depth_w_r;
  assign out_hit_index_x  = out_hit.index_x;
  assign out_hit_index_y  = out_hit.index_y;

endmodule
`default_nettype wire

// ===== hw/rtl/shep_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shep_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shep_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [16:0] rem_r;
  logic [15:0] lo_r;
  logic [15:0] q_r;
  logic [16:0] dv_r;
  logic        zero_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [17:0] trial;

  assign trial = {rem_r, lo_r[15]} - {1'b0, dv_r};
  assign done = done_r;
  assign quotient = zero_r ? 16'd0 : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend[31:16]};
      lo_r   <= dividend[15:0];
      dv_r   <= divisor;
      zero_r <= (divisor == 17'd0);
      q_r    <= 16'd0;
    end else if (busy_r) begin
      lo_r <= {lo_r[14:0], 1'b0};
      if (!trial[17]) begin
        rem_r <= trial[16:0];
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= {rem_r[15:0], lo_r[15]};
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shep_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shep_obuf
  import shep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire hit_t hit,
  output logic      push_ok,
  input  wire logic flush,
  output logic      flush_ok,
  output logic      out_valid,
  input  wire logic out_ready,
  output hit_t      out_hit,
  output logic      out_last
);

  hit_t hold_r;
  logic hold_v_r, hold_v_nxt;
  hit_t out_hit_r;
  logic out_last_r;
  logic out_v_r, out_v_nxt;
  logic out_free;
  logic mv;
  logic mv_last;

  assign out_free = !out_v_r || out_ready;
  assign push_ok = !hold_v_r || out_free;
  assign flush_ok = !hold_v_r || out_free;
  assign out_valid = out_v_r;
  assign out_hit = out_hit_r;
  assign out_last = out_last_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    out_v_nxt  = out_v_r && !out_ready;
    mv         = 1'b0;
    mv_last    = 1'b0;
    if (push && push_ok) begin
      mv         = hold_v_r;
      hold_v_nxt = 1'b1;
    end else if (flush && hold_v_r && out_free) begin
      mv         = 1'b1;
      mv_last    = 1'b1;
      hold_v_nxt = 1'b0;
    end
    if (mv) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) begin
      out_hit_r  <= hold_r;
      out_last_r <= mv_last;
    end
    if (push && push_ok) begin
      hold_r <= hit;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/shep_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module shep_ctrl
  import shep_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire logic              in_side,
  input  wire logic [7:0]        in_det,
  input  wire logic              in_last,
  input  wire sig_t              in_sig,
  input  wire logic [7:0]        det_sel,
  input  wire logic [15:0]       tol,
  output logic                   idle,
  output ram_wr_t                x_wr,
  output logic [ADDR_W-1:0]      x_raddr,
  input  wire sig_t              x_rdata,
  output ram_wr_t                y_wr,
  output logic [ADDR_W-1:0]      y_raddr,
  input  wire sig_t              y_rdata,
  output logic                   div_start,
  output logic [31:0]            div_dividend,
  output logic [16:0]            div_divisor,
  input  wire logic              div_done,
  input  wire logic [15:0]       div_q,
  output logic                   push,
  output hit_t                   hit,
  input  wire logic              push_ok,
  output logic                   flush,
  input  wire logic              flush_ok
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD0    = 4'd1;
  localparam logic [3:0] S_RD1    = 4'd2;
  localparam logic [3:0] S_CAP1   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_ISSUE  = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIV0   = 4'd7;
  localparam logic [3:0] S_DIVW   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_RK_LI  = 4'd10;
  localparam logic [3:0] S_RK_GI  = 4'd11;
  localparam logic [3:0] S_RK_SC  = 4'd12;
  localparam logic [3:0] S_PM_RD  = 4'd13;
  localparam logic [3:0] S_PM_GET = 4'd14;
  localparam logic [3:0] S_FLUSH  = 4'd15;

  function automatic logic [16:0] adiff(input logic [16:0] a, input logic [16:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic win(input logic [16:0] a, input logic [16:0] b,
                               input logic [15:0] t);
    return adiff(a, b) <= {1'b0, t};
  endfunction

  function automatic plan_t p12(input logic xs, input logic [15:0] ex,
                                input logic [15:0] ey0, input logic [15:0] ey1,
                                input logic [15:0] t);
    plan_t p;
    logic [16:0] tot;
    logic [16:0] d0;
    logic [16:0] d1;
    p   = '0;
    tot = {1'b0, ey0} + {1'b0, ey1};
    d0  = adiff({1'b0, ex}, {1'b0, ey0});
    d1  = adiff({1'b0, ex}, {1'b0, ey1});
    if (win({1'b0, ex}, tot, t)) begin
      p.n  = 2'd2;
      p.h0 = '{xs: xs, ys: 1'b0, kind: K_SPLIT_X};
      p.h1 = '{xs: xs, ys: 1'b1, kind: K_SPLIT_X};
    end else if (d0 <= {1'b0, t} && d0 <= d1) begin
      p.n  = 2'd1;
      p.h0 = '{xs: xs, ys: 1'b0, kind: K_MEAN};
    end else if (d1 <= {1'b0, t} && d1 <= d0) begin
      p.n  = 2'd1;
      p.h0 = '{xs: xs, ys: 1'b1, kind: K_MEAN};
    end
    return p;
  endfunction

  function automatic plan_t p21(input logic ys, input logic [15:0] ey,
                                input logic [15:0] ex0, input logic [15:0] ex1,
                                input logic [15:0] t);
    plan_t p;
    logic [16:0] tot;
    logic [16:0] d0;
    logic [16:0] d1;
    p   = '0;
    tot = {1'b0, ex0} + {1'b0, ex1};
    d0  = adiff({1'b0, ey}, {1'b0, ex0});
    d1  = adiff({1'b0, ey}, {1'b0, ex1});
    if (win({1'b0, ey}, tot, t)) begin
      p.n  = 2'd2;
      p.h0 = '{xs: 1'b0, ys: ys, kind: K_SPLIT_Y};
      p.h1 = '{xs: 1'b1, ys: ys, kind: K_SPLIT_Y};
    end else if (d0 <= {1'b0, t} && d0 <= d1) begin
      p.n  = 2'd1;
      p.h0 = '{xs: 1'b0, ys: ys, kind: K_MEAN};
    end else if (d1 <= {1'b0, t} && d1 <= d0) begin
      p.n  = 2'd1;
      p.h0 = '{xs: 1'b1, ys: ys, kind: K_MEAN};
    end
    return p;
  endfunction

  function automatic plan_t p22(input logic [15:0] ex0, input logic [15:0] ex1,
                                input logic [15:0] ey0, input logic [15:0] ey1,
                                input logic [15:0] t);
    plan_t p;
    logic [16:0] sx;
    logic [16:0] sy;
    p  = '0;
    sx = {1'b0, ex0} + {1'b0, ex1};
    sy = {1'b0, ey0} + {1'b0, ey1};
    if (win(sx, sy, t)) begin
      if (win({1'b0, ex0}, {1'b0, ey0}, t) && win({1'b0, ex1}, {1'b0, ey1}, t)) begin
        p.n  = 2'd2;
        p.h0 = '{xs: 1'b0, ys: 1'b0, kind: K_DIRECT};
        p.h1 = '{xs: 1'b1, ys: 1'b1, kind: K_DIRECT};
      end else if (win({1'b0, ex0}, {1'b0, ey1}, t) &&
                   win({1'b0, ex1}, {1'b0, ey0}, t)) begin
        p.n  = 2'd2;
        p.h0 = '{xs: 1'b0, ys: 1'b1, kind: K_DIRECT};
        p.h1 = '{xs: 1'b1, ys: 1'b0, kind: K_DIRECT};
      end
    end else if (sx < sy) begin
      if (win(sx, {1'b0, ey0}, t)) begin
        p = p21(1'b0, ey0, ex0, ex1, t);
      end else if (win(sx, {1'b0, ey1}, t)) begin
        p = p21(1'b1, ey1, ex0, ex1, t);
      end
    end else begin
      if (win({1'b0, ex0}, sy, t)) begin
        p = p12(1'b0, ex0, ey0, ey1, t);
      end else if (win({1'b0, ex1}, sy, t)) begin
        p = p12(1'b1, ex1, ey0, ey1, t);
      end
    end
    return p;
  endfunction

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_x_r, cnt_x_nxt;
  logic [CNT_W-1:0]  cnt_y_r, cnt_y_nxt;
  logic [RES_W-1:0]  nhit_r, nhit_nxt;
  sig_t              x0_r, x1_r, y0_r, y1_r;
  plan_t             plan_r;
  plan_t             plan_c;
  logic              hp_r, hp_nxt;
  logic              many_r, many_nxt;
  logic [31:0]       prod_r;
  logic [16:0]       tot_r;
  logic [15:0]       share_r;
  logic              side_r, side_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [ADDR_W-1:0] pj_r, pj_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] rank_r, rank_nxt;
  logic [15:0]       ei_r;
  logic [ADDR_W-1:0] ordx_r [MAX_SIGNALS];
  logic [ADDR_W-1:0] ordy_r [MAX_SIGNALS];
  logic              ord_we;

  logic              store_ok;
  logic [CNT_W-1:0]  n_cur;
  logic [CNT_W-1:0]  m_cnt;
  sig_t              rd_cur;
  hit_sel_t          cur;
  sig_t              xs_sig, ys_sig;
  logic [15:0]       mul_a, mul_b;
  logic [16:0]       mul_tot;
  logic [16:0]       mean_sum;
  logic              small_case;
  logic              win_pm;

  assign idle = (state_r == S_IDLE);
  assign store_ok = in_acc && (in_det == det_sel);
  assign n_cur = side_r ? cnt_y_r : cnt_x_r;
  assign m_cnt = (cnt_x_r < cnt_y_r) ? cnt_x_r : cnt_y_r;
  assign rd_cur = side_r ? y_rdata : x_rdata;
  assign cur = hp_r ? plan_r.h1 : plan_r.h0;
  assign xs_sig = cur.xs ? x1_r : x0_r;
  assign ys_sig = cur.ys ? y1_r : y0_r;
  assign mean_sum = {1'b0, xs_sig.energy} + {1'b0, ys_sig.energy};
  assign small_case = (cnt_x_r == CNT_W'(1) || cnt_x_r == CNT_W'(2)) &&
                      (cnt_y_r == CNT_W'(1) || cnt_y_r == CNT_W'(2));
  assign win_pm = win({1'b0, x_rdata.energy}, {1'b0, y_rdata.energy}, tol);

  always_comb begin
    if (cur.kind == K_SPLIT_X) begin
      mul_a   = xs_sig.energy;
      mul_b   = ys_sig.energy;
      mul_tot = {1'b0, y0_r.energy} + {1'b0, y1_r.energy};
    end else begin
      mul_a   = ys_sig.energy;
      mul_b   = xs_sig.energy;
      mul_tot = {1'b0, x0_r.energy} + {1'b0, x1_r.energy};
    end
  end

  always_comb begin
    if (cnt_x_r == CNT_W'(1) && cnt_y_r == CNT_W'(1)) begin
      plan_c    = '0;
      plan_c.n  = 2'd1;
      plan_c.h0 = '{xs: 1'b0, ys: 1'b0, kind: K_MEAN};
    end else if (cnt_x_r == CNT_W'(1)) begin
      plan_c = p12(1'b0, x0_r.energy, y0_r.energy, y1_r.energy, tol);
    end else if (cnt_y_r == CNT_W'(1)) begin
      plan_c = p21(1'b0, y0_r.energy, x0_r.energy, x1_r.energy, tol);
    end else begin
      plan_c = p22(x0_r.energy, x1_r.energy, y0_r.energy, y1_r.energy, tol);
    end
  end

  always_comb begin
    hit.energy   = xs_sig.energy;
    hit.energy_x = xs_sig.energy;
    hit.energy_y = ys_sig.energy;
    case (cur.kind)
      K_MEAN: begin
        hit.energy = mean_sum[16:1];
      end
      K_SPLIT_X: begin
        hit.energy   = ys_sig.energy;
        hit.energy_x = share_r;
      end
      K_SPLIT_Y: begin
        hit.energy_y = share_r;
      end
      default: begin
      end
    endcase
    hit.pos_x   = xs_sig.position;
    hit.pos_y   = ys_sig.position;
    hit.width_x = xs_sig.strip_width;
    hit.width_y = ys_sig.strip_width;
    hit.index_x = xs_sig.signal_index;
    hit.index_y = ys_sig.signal_index;
  end

  assign div_dividend = prod_r;
  assign div_divisor = tot_r;

  always_comb begin
    state_nxt = state_r;
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    nhit_nxt  = nhit_r;
    hp_nxt    = hp_r;
    many_nxt  = many_r;
    side_nxt  = side_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    pj_nxt    = pj_r;
    pend_nxt  = pend_r;
    rank_nxt  = rank_r;
    ord_we    = 1'b0;
    x_wr      = '{we: 1'b0, addr: cnt_x_r[ADDR_W-1:0], data: in_sig};
    y_wr      = '{we: 1'b0, addr: cnt_y_r[ADDR_W-1:0], data: in_sig};
    x_raddr   = '0;
    y_raddr   = '0;
    div_start = 1'b0;
    push      = 1'b0;
    flush     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (store_ok && !in_side && cnt_x_r < CNT_W'(MAX_SIGNALS)) begin
          x_wr.we   = 1'b1;
          cnt_x_nxt = cnt_x_r + CNT_W'(1);
        end
        if (store_ok && in_side && cnt_y_r < CNT_W'(MAX_SIGNALS)) begin
          y_wr.we   = 1'b1;
          cnt_y_nxt = cnt_y_r + CNT_W'(1);
        end
        if (in_acc && in_last) begin
          nhit_nxt  = '0;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        x_raddr   = ADDR_W'(1);
        y_raddr   = ADDR_W'(1);
        state_nxt = S_CAP1;
      end
      S_CAP1: begin
        if (small_case) begin
          many_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end else if (m_cnt == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          many_nxt  = 1'b1;
          side_nxt  = 1'b0;
          i_nxt     = '0;
          state_nxt = S_RK_LI;
        end
      end
      S_DECIDE: begin
        hp_nxt    = 1'b0;
        state_nxt = (plan_c.n == 2'd0) ? S_FLUSH : S_ISSUE;
      end
      S_ISSUE: begin
        if (nhit_r >= RES_W'(MAX_RESULTS)) begin
          state_nxt = S_FLUSH;
        end else if (cur.kind == K_SPLIT_X || cur.kind == K_SPLIT_Y) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        push = 1'b1;
        if (push_ok) begin
          nhit_nxt = nhit_r + RES_W'(1);
          if (!many_r && !hp_r && plan_r.n == 2'd2) begin
            hp_nxt    = 1'b1;
            state_nxt = S_ISSUE;
          end else if (many_r && k_r != m_cnt - CNT_W'(1)) begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_PM_RD;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_RK_LI: begin
        x_raddr   = i_r[ADDR_W-1:0];
        y_raddr   = i_r[ADDR_W-1:0];
        state_nxt = S_RK_GI;
      end
      S_RK_GI: begin
        j_nxt     = '0;
        pend_nxt  = 1'b0;
        rank_nxt  = '0;
        state_nxt = S_RK_SC;
      end
      S_RK_SC: begin
        if (j_r != n_cur) begin
          x_raddr  = j_r[ADDR_W-1:0];
          y_raddr  = j_r[ADDR_W-1:0];
          j_nxt    = j_r + CNT_W'(1);
          pend_nxt = 1'b1;
          pj_nxt   = j_r[ADDR_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (rd_cur.energy > ei_r ||
                       (rd_cur.energy == ei_r && pj_r > i_r[ADDR_W-1:0]))) begin
          rank_nxt = rank_r + ADDR_W'(1);
        end
        if (j_r == n_cur && !pend_r) begin
          ord_we = 1'b1;
          if (i_r == n_cur - CNT_W'(1)) begin
            i_nxt = '0;
            if (!side_r) begin
              side_nxt  = 1'b1;
              state_nxt = S_RK_LI;
            end else begin
              k_nxt     = '0;
              state_nxt = S_PM_RD;
            end
          end else begin
            i_nxt     = i_r + CNT_W'(1);
            state_nxt = S_RK_LI;
          end
        end
      end
      S_PM_RD: begin
        x_raddr   = ordx_r[k_r[ADDR_W-1:0]];
        y_raddr   = ordy_r[k_r[ADDR_W-1:0]];
        state_nxt = S_PM_GET;
      end
      S_PM_GET: begin
        hp_nxt = 1'b0;
        if (win_pm) begin
          state_nxt = S_ISSUE;
        end else if (k_r != m_cnt - CNT_W'(1)) begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_PM_RD;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        flush = 1'b1;
        if (flush_ok) begin
          cnt_x_nxt = '0;
          cnt_y_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_x_r <= '0;
      cnt_y_r <= '0;
      nhit_r  <= '0;
      hp_r    <= 1'b0;
      many_r  <= 1'b0;
      side_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      pend_r  <= 1'b0;
      rank_r  <= '0;
      pj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_x_r <= cnt_x_nxt;
      cnt_y_r <= cnt_y_nxt;
      nhit_r  <= nhit_nxt;
      hp_r    <= hp_nxt;
      many_r  <= many_nxt;
      side_r  <= side_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
      rank_r  <= rank_nxt;
      pj_r    <= pj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD1) begin
      x0_r <= x_rdata;
      y0_r <= y_rdata;
    end
    if (state_r == S_CAP1) begin
      x1_r <= x_rdata;
      y1_r <= y_rdata;
    end
    if (state_r == S_PM_GET) begin
      x0_r   <= x_rdata;
      y0_r   <= y_rdata;
      plan_r <= '{n: 2'd1, h0: '{xs: 1'b0, ys: 1'b0, kind: K_MEAN}, h1: '0};
    end
    if (state_r == S_DECIDE) begin
      plan_r <= plan_c;
    end
    if (state_r == S_MUL) begin
      prod_r <= mul_a * mul_b;
      tot_r  <= mul_tot;
    end
    if (state_r == S_DIVW && div_done) begin
      share_r <= div_q;
    end
    if (state_r == S_RK_GI) begin
      ei_r <= rd_cur.energy;
    end
    if (ord_we) begin
      if (side_r) begin
        ordy_r[rank_r] <= i_r[ADDR_W-1:0];
      end else begin
        ordx_r[rank_r] <= i_r[ADDR_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/strip_hit_energy_pairing_unit_tb.sv =====
`timescale 1ns / 1ps
module strip_hit_energy_pairing_unit_tb;
  import shep_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 1000;

  typedef struct packed {
    logic        side;
    logic [7:0]  det;
    logic [15:0] energy;
    logic [15:0] pos;
    logic [15:0] width;
    logic [7:0]  idx;
    logic        last;
  } strip_word_t;

  typedef struct packed {
    logic [15:0]        e;
    logic [15:0]        ex;
    logic [15:0]        ey;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [15:0]        wx;
    logic [15:0]        wy;
    logic [15:0]        wz;
    logic [7:0]         ix;
    logic [7:0]         iy;
    logic               last;
  } hit_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_strip_side = 1'b0;
  logic [7:0] in_detector_id = '0;
  logic [15:0] in_energy = '0;
  logic signed [15:0] in_position = '0;
  logic [15:0] in_strip_width = '0;
  logic [7:0] in_signal_index = '0;
  logic in_last_of_event = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_hit_energy, out_hit_energy_x, out_hit_energy_y;
  logic signed [15:0] out_hit_pos_x, out_hit_pos_y, out_hit_pos_z;
  logic [15:0] out_hit_width_x, out_hit_width_y, out_hit_width_z;
  logic [7:0] out_hit_index_x, out_hit_index_y;
  logic out_last_hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  strip_hit_energy_pairing_unit uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies
  logic [7:0] det_sel = 8'd0;
  int tol = 80;
  logic [15:0] zpos = '0;
  logic [15:0] zwid = '0;

  sig_t x_store[MAX_SIGNALS];
  sig_t y_store[MAX_SIGNALS];
  int x_cnt = 0, y_cnt = 0;
  hit_word_t event_hits[$];
  hit_word_t hits_due[$];
  strip_word_t words_pending[$];

  int errors = 0, hits_seen = 0, events_done = 0, words_sent = 0, cycles = 0;
  int in_gap = 0, out_gap = 0;
  logic burst = 1'b0;
  logic stall_out = 1'b0;

  function automatic longint gap_of(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic bit agrees(longint d);
    return d <= longint'(tol);
  endfunction

  function automatic int portion(int single, int part, int total);
    if (total == 0) return 0;
    return int'((longint'(single) * part) / total);
  endfunction

  function automatic void add_hit(int e, int ex, int ey, sig_t xs, sig_t ys);
    hit_word_t h;
    if (event_hits.size() >= MAX_RESULTS) return;
    h.e = e[15:0];
    h.ex = ex[15:0];
    h.ey = ey[15:0];
    h.px = xs.position;
    h.py = ys.position;
    h.pz = zpos;
    h.wx = xs.strip_width;
    h.wy = ys.strip_width;
    h.wz = zwid;
    h.ix = xs.signal_index;
    h.iy = ys.signal_index;
    h.last = 1'b0;
    event_hits.push_back(h);
  endfunction

  function automatic void mean_hit(sig_t xs, sig_t ys);
    add_hit((int'(xs.energy) + int'(ys.energy)) >> 1, xs.energy, ys.energy, xs, ys);
  endfunction

  function automatic void one_two(sig_t xs, sig_t y0, sig_t y1);
    int tot;
    longint d0, d1;
    tot = int'(y0.energy) + int'(y1.energy);
    d0 = gap_of(xs.energy, y0.energy);
    d1 = gap_of(xs.energy, y1.energy);
    if (agrees(gap_of(xs.energy, tot))) begin
      add_hit(y0.energy, portion(xs.energy, y0.energy, tot), y0.energy, xs, y0);
      add_hit(y1.energy, portion(xs.energy, y1.energy, tot), y1.energy, xs, y1);
    end else if (agrees(d0) && d0 <= d1) begin
      mean_hit(xs, y0);
    end else if (agrees(d1) && d1 <= d0) begin
      mean_hit(xs, y1);
    end
  endfunction

  function automatic void two_one(sig_t x0, sig_t x1, sig_t ys);
    int tot;
    longint d0, d1;
    tot = int'(x0.energy) + int'(x1.energy);
    d0 = gap_of(ys.energy, x0.energy);
    d1 = gap_of(ys.energy, x1.energy);
    if (agrees(gap_of(ys.energy, tot))) begin
      add_hit(x0.energy, x0.energy, portion(ys.energy, x0.energy, tot), x0, ys);
      add_hit(x1.energy, x1.energy, portion(ys.energy, x1.energy, tot), x1, ys);
    end else if (agrees(d0) && d0 <= d1) begin
      mean_hit(x0, ys);
    end else if (agrees(d1) && d1 <= d0) begin
      mean_hit(x1, ys);
    end
  endfunction

  function automatic void two_two(sig_t x0, sig_t x1, sig_t y0, sig_t y1);
    longint sx, sy, dev;
    sx = longint'(x0.energy) + x1.energy;
    sy = longint'(y0.energy) + y1.energy;
    dev = sx - sy;
    if (agrees(gap_of(dev, 0))) begin
      if (agrees(gap_of(x0.energy, y0.energy)) && agrees(gap_of(x1.energy, y1.energy))) begin
        add_hit(x0.energy, x0.energy, y0.energy, x0, y0);
        add_hit(x1.energy, x1.energy, y1.energy, x1, y1);
      end else if (agrees(gap_of(x0.energy, y1.energy)) &&
                   agrees(gap_of(x1.energy, y0.energy))) begin
        add_hit(x0.energy, x0.energy, y1.energy, x0, y1);
        add_hit(x1.energy, x1.energy, y0.energy, x1, y0);
      end
    end else if (dev < 0) begin
      if (agrees(gap_of(sx, y0.energy))) two_one(x0, x1, y0);
      else if (agrees(gap_of(sx, y1.energy))) two_one(x0, x1, y1);
    end else begin
      if (agrees(gap_of(x0.energy, sy))) one_two(x0, y0, y1);
      else if (agrees(gap_of(x1.energy, sy))) one_two(x1, y0, y1);
    end
  endfunction

  function automatic void by_rank();
    int ox[MAX_SIGNALS], oy[MAX_SIGNALS];
    int m, r;
    m = x_cnt < y_cnt ? x_cnt : y_cnt;
    for (int i = 0; i < x_cnt; i++) begin
      r = 0;
      for (int j = 0; j < x_cnt; j++)
        if (x_store[j].energy > x_store[i].energy ||
            (x_store[j].energy == x_store[i].energy && j > i)) r++;
      ox[r] = i;
    end
    for (int i = 0; i < y_cnt; i++) begin
      r = 0;
      for (int j = 0; j < y_cnt; j++)
        if (y_store[j].energy > y_store[i].energy ||
            (y_store[j].energy == y_store[i].energy && j > i)) r++;
      oy[r] = i;
    end
    for (int i = 0; i < m; i++)
      if (agrees(gap_of(x_store[ox[i]].energy, y_store[oy[i]].energy)))
        mean_hit(x_store[ox[i]], y_store[oy[i]]);
  endfunction

  function automatic void take_strip(strip_word_t w);
    sig_t s;
    s.energy = w.energy;
    s.position = w.pos;
    s.strip_width = w.width;
    s.signal_index = w.idx;
    if (w.det == det_sel) begin
      if (!w.side && x_cnt < MAX_SIGNALS) x_store[x_cnt++] = s;
      if (w.side && y_cnt < MAX_SIGNALS) y_store[y_cnt++] = s;
    end
    if (!w.last) return;
    event_hits.delete();
    if (x_cnt == 1 && y_cnt == 1) mean_hit(x_store[0], y_store[0]);
    else if (x_cnt == 1 && y_cnt == 2) one_two(x_store[0], y_store[0], y_store[1]);
    else if (x_cnt == 2 && y_cnt == 1) two_one(x_store[0], x_store[1], y_store[0]);
    else if (x_cnt == 2 && y_cnt == 2)
      two_two(x_store[0], x_store[1], y_store[0], y_store[1]);
    else by_rank();
    if (event_hits.size() > 0) event_hits[event_hits.size() - 1].last = 1'b1;
    foreach (event_hits[k]) hits_due.push_back(event_hits[k]);
    x_cnt = 0;
    y_cnt = 0;
    events_done++;
  endfunction

  function automatic int draw_wait();
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (hit %0d)", what, got, want, hits_seen);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (words_pending.size() > 0) begin
      strip_word_t w;
      w = words_pending.pop_front();
      in_strip_side <= w.side;
      in_detector_id <= w.det;
      in_energy <= w.energy;
      in_position <= w.pos;
      in_strip_width <= w.width;
      in_signal_index <= w.idx;
      in_last_of_event <= w.last;
      in_valid <= 1'b1;
      in_gap <= draw_wait();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(posedge clk) begin
    int w;
    if (!rst_n || stall_out) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = draw_wait();
      out_ready <= (w == 0);
      out_gap <= (w > 0) ? w - 1 : 0;
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    strip_word_t w;
    hit_word_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        w = {in_strip_side, in_detector_id, in_energy, in_position, in_strip_width,
             in_signal_index, in_last_of_event};
        take_strip(w);
      end
      if (out_valid && out_ready) begin
        got = {out_hit_energy, out_hit_energy_x, out_hit_energy_y, out_hit_pos_x,
               out_hit_pos_y, out_hit_pos_z, out_hit_width_x, out_hit_width_y,
               out_hit_width_z, out_hit_index_x, out_hit_index_y, out_last_hit};
        if (hits_due.size() == 0) begin
          report("unexpected hit", got.e, 0);
        end else begin
          want = hits_due.pop_front();
          if (got.e !== want.e) report("hit_energy", got.e, want.e);
          if (got.ex !== want.ex) report("hit_energy_x", got.ex, want.ex);
          if (got.ey !== want.ey) report("hit_energy_y", got.ey, want.ey);
          if (got.px !== want.px) report("hit_pos_x", got.px, want.px);
          if (got.py !== want.py) report("hit_pos_y", got.py, want.py);
          if (got.pz !== want.pz) report("hit_pos_z", got.pz, want.pz);
          if (got.wx !== want.wx) report("hit_width_x", got.wx, want.wx);
          if (got.wy !== want.wy) report("hit_width_y", got.wy, want.wy);
          if (got.wz !== want.wz) report("hit_width_z", got.wz, want.wz);
          if (got.ix !== want.ix) report("hit_index_x", got.ix, want.ix);
          if (got.iy !== want.iy) report("hit_index_y", got.iy, want.iy);
          if (got.last !== want.last) report("last_hit", got.last, want.last);
        end
        hits_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hits outstanding", cycles, hits_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DET_SEL:   det_sel = data[7:0];
      CFG_TOL:       tol = data;
      CFG_DEPTH_POS: zpos = data;
      CFG_DEPTH_W:   zwid = data;
      default: ;
    endcase
  endtask

  task automatic push_full(logic side, logic [7:0] det, int e, logic [15:0] pos,
                           logic [15:0] wd, logic [7:0] idx, logic last);
    strip_word_t w;
    w.side = side;
    w.det = det;
    w.energy = e[15:0];
    w.pos = pos;
    w.width = wd;
    w.idx = idx;
    w.last = last;
    words_pending.push_back(w);
    words_sent++;
  endtask

  task automatic push_strip(logic side, logic [7:0] det, int e, logic last);
    push_full(side, det, e, 16'($urandom), 16'($urandom), 8'($urandom), last);
  endtask

  function automatic int any_energy();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 300);
      2: return 65535 - $urandom_range(0, 300);
      default: return $urandom_range(1000, 30000);
    endcase
  endfunction

  function automatic int near(int v, int d);
    int r;
    r = v + int'($urandom_range(0, 2 * d + 2)) - d - 1;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r;
  endfunction

  // one event: nx x-side and ny y-side words, shuffled, with foreign noise
  task automatic make_event(int nx, int ny, int mode);
    int ex[$], ey[$];
    bit sides[$];
    int d, xi, yi, j;
    bit t;
    logic [7:0] other;
    d = (tol < 300) ? tol : 300;
    other = det_sel ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < nx; k++) ex.push_back(any_energy());
    for (int k = 0; k < ny; k++)
      ey.push_back((mode == 1 && nx > 0) ? near(ex[k % nx], d) : any_energy());
    if (mode == 2 && nx == 1 && ny >= 2) ex[0] = near(ey[0] + ey[1], d);
    if (mode == 2 && ny == 1 && nx >= 2) ey[0] = near(ex[0] + ex[1], d);
    for (int k = 0; k < nx; k++) sides.push_back(1'b0);
    for (int k = 0; k < ny; k++) sides.push_back(1'b1);
    for (int k = sides.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = sides[k];
      sides[k] = sides[j];
      sides[j] = t;
    end
    if (sides.size() == 0) begin
      push_strip(1'($urandom_range(0, 1)), other, any_energy(), 1'b1);
      return;
    end
    xi = 0;
    yi = 0;
    foreach (sides[k]) begin
      if ($urandom_range(0, 7) == 0)
        push_strip(1'($urandom_range(0, 1)), other, any_energy(), 1'b0);
      if (!sides[k]) push_strip(1'b0, det_sel, ex[xi++], k == sides.size() - 1);
      else push_strip(1'b1, det_sel, ey[yi++], k == sides.size() - 1);
    end
  endtask

  task automatic corner_events();
    push_full(1'b0, det_sel, 65535, 16'h8000, 16'hFFFF, 8'hFF, 1'b0);
    push_full(1'b1, det_sel, 65535, 16'h7FFF, 16'h0000, 8'h00, 1'b1);
    push_full(1'b0, det_sel, 0, 16'h7FFF, 16'h0000, 8'h00, 1'b0);
    push_full(1'b1, det_sel, 0, 16'h8000, 16'hFFFF, 8'hFF, 1'b1);
    // split of a single x over two y
    push_strip(1'b0, det_sel, 1000, 1'b0);
    push_strip(1'b1, det_sel, 400, 1'b0);
    push_strip(1'b1, det_sel, 600, 1'b1);
    // nearer y wins, then one y split over two x
    push_strip(1'b1, det_sel, 510, 1'b0);
    push_strip(1'b1, det_sel, 3000, 1'b0);
    push_strip(1'b0, det_sel, 500, 1'b1);
    push_strip(1'b0, det_sel, 700, 1'b0);
    push_strip(1'b0, det_sel, 300, 1'b0);
    push_strip(1'b1, det_sel, 1000, 1'b1);
    // 2x2 straight, then crossed
    push_strip(1'b0, det_sel, 100, 1'b0);
    push_strip(1'b0, det_sel, 900, 1'b0);
    push_strip(1'b1, det_sel, 110, 1'b0);
    push_strip(1'b1, det_sel, 890, 1'b1);
    push_strip(1'b0, det_sel, 100, 1'b0);
    push_strip(1'b0, det_sel, 900, 1'b0);
    push_strip(1'b1, det_sel, 890, 1'b0);
    push_strip(1'b1, det_sel, 110, 1'b1);
    // 2x2 falling back to 2x1
    push_strip(1'b0, det_sel, 100, 1'b0);
    push_strip(1'b0, det_sel, 200, 1'b0);
    push_strip(1'b1, det_sel, 300, 1'b0);
    push_strip(1'b1, det_sel, 5000, 1'b1);
    // zero divisor
    push_strip(1'b0, det_sel, 0, 1'b0);
    push_strip(1'b1, det_sel, 0, 1'b0);
    push_strip(1'b1, det_sel, 0, 1'b1);
    // ties in rank order
    push_strip(1'b0, det_sel, 500, 1'b0);
    push_strip(1'b0, det_sel, 500, 1'b0);
    push_strip(1'b0, det_sel, 200, 1'b0);
    push_strip(1'b1, det_sel, 500, 1'b0);
    push_strip(1'b1, det_sel, 500, 1'b0);
    push_strip(1'b1, det_sel, 205, 1'b1);
    // event closed by a word from another detector
    push_strip(1'b0, det_sel, 400, 1'b0);
    push_strip(1'b1, det_sel ^ 8'h05, 400, 1'b1);
  endtask

  task automatic drain();
    while (words_pending.size() > 0 || in_valid || hits_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] sel[6];
    logic [15:0] tl[6], zp[6], zw[6];
    int r, nx, ny, start;
    sel = '{8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom), 8'd7};
    tl = '{16'd80, 16'd0, 16'hFFFF, 16'd300, 16'($urandom_range(0, 2000)), 16'd40};
    zp = '{16'h0000, 16'h7FFF, 16'h8000, 16'($urandom), 16'($urandom), 16'($urandom)};
    zw = '{16'h0000, 16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom), 16'($urandom)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_DET_SEL, {8'd0, sel[ph]});
      write_reg(CFG_TOL, tl[ph]);
      write_reg(CFG_DEPTH_POS, zp[ph]);
      write_reg(CFG_DEPTH_W, zw[ph]);
      burst <= (ph == 4);
      if (ph == 0) corner_events();
      start = words_sent;
      while (words_sent - start < 66) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          nx = $urandom_range(0, 3);
          ny = $urandom_range(0, 3);
        end else if (r < 9) begin
          nx = $urandom_range(1, 6);
          ny = $urandom_range(1, 6);
        end else begin
          nx = $urandom_range(12, 18);
          ny = $urandom_range(12, 18);
        end
        make_event(nx, ny, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2));
      end
      if (ph == 3) begin
        @(posedge clk);
        stall_out <= 1'b1;
        repeat (800) @(posedge clk);
        stall_out <= 1'b0;
      end
      drain();
    end
    $display("%0d strip words over %0d events and 6 register settings", words_sent,
             events_done);
    $display("%0d hits compared, %0d mismatches", hits_seen, errors);
    if (errors == 0 && hits_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/shep_pkg.sv
hw/rtl/shep_ram.sv
hw/rtl/shep_div.sv
hw/rtl/shep_obuf.sv
hw/rtl/shep_ctrl.sv
hw/rtl/strip_hit_energy_pairing_unit.sv
sim/strip_hit_energy_pairing_unit_tb.sv
